// File: hdl/vtpd_pkg.sv
// Shared constants for the vertex transform and perspective divide block.
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 16;

   // Matrix row registers: four coefficient slots of SLOT_WIDTH bits each.
   localparam int ROW_WIDTH       = 64;
   localparam int SLOT_WIDTH      = 16;
   localparam int NUM_ROWS        = 4;
   localparam int NUM_COLS        = 4;
   localparam int ROW_SEL_WIDTH   = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes on the CSR port.
   localparam logic [CSR_INDEX_WIDTH-1:0] ROW0_IDX = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] ROW1_IDX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] ROW2_IDX = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] ROW3_IDX = 3'd3;

   // Identity matrix in Q4.12.
   localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
   localparam logic [ROW_WIDTH-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

endpackage
`default_nettype wire

// File: hdl/vtpd_if.sv
// Point and projected-result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface vtpd_req_if #(
   parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] in_x;
   logic signed [COORD_WIDTH-1:0] in_y;
   logic signed [COORD_WIDTH-1:0] in_z;
   logic signed [COORD_WIDTH-1:0] in_w;

   modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                   input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                   output ready);
endinterface

interface vtpd_rsp_if #(
   parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic                          div_zero;
   logic                          saturated;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output div_zero, output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input div_zero, input saturated, output ready);
endinterface
`default_nettype wire

// File: hdl/vertex_transform_perspective_divide.sv
// Top level: 4x4 homogeneous transform followed by a pipelined perspective divide.
// Throughput: one word per cycle unless rsp stalls; the divide is one restoring step per stage,
//   COORD_WIDTH stages, three lanes side by side, so a new point enters every cycle without a stall.
// The whole pipe advances together; a stalled rsp holds every stage in place.
// Reset (synchronous, active high) clears all valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_perspective_divide #(
   parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = vtpd_pkg::COEF_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   vtpd_req_if.sink                                   req_bus,
   vtpd_rsp_if.source                                 rsp_bus,
   input  wire logic                                  csr_we,
   input  wire logic [vtpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [vtpd_pkg::ROW_WIDTH-1:0]        csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int FRAC  = COORD_WIDTH / 2;
   localparam int SH    = COORD_WIDTH - FRAC;     // quotient bits above the fraction
   localparam int PW    = COORD_WIDTH + COEF_WIDTH; // one product
   localparam int SW    = PW + 2;                  // sum of four products
   localparam int RW    = SW + 1;                  // divider remainder
   localparam int DEPTH = COORD_WIDTH + 5;         // stages holding a valid bit
   localparam int NR    = vtpd_pkg::NUM_ROWS;
   localparam int NC    = vtpd_pkg::NUM_COLS;

   // ---------------------------------------------------------------
   // Matrix row registers
   // ---------------------------------------------------------------
   logic [vtpd_pkg::ROW_WIDTH-1:0] row_ff [0:NR-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= vtpd_pkg::ROW0_RESET;
         row_ff[1] <= vtpd_pkg::ROW1_RESET;
         row_ff[2] <= vtpd_pkg::ROW2_RESET;
         row_ff[3] <= vtpd_pkg::ROW3_RESET;
      end else if (csr_we) begin
         // drop writes beyond the last row
         unique case (csr_index)
            vtpd_pkg::ROW0_IDX: row_ff[0] <= csr_wdata;
            vtpd_pkg::ROW1_IDX: row_ff[1] <= csr_wdata;
            vtpd_pkg::ROW2_IDX: row_ff[2] <= csr_wdata;
            vtpd_pkg::ROW3_IDX: row_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Flow control: one enable for the whole pipe
   // ---------------------------------------------------------------
   logic [DEPTH-1:0] valid_ff;
   logic             adv;
   logic             req_fire;

   assign adv           = !valid_ff[DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign req_fire      = req_bus.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_fire};
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: sixteen coefficient-by-coordinate products
   // ---------------------------------------------------------------
   logic signed [CW-1:0]         pt   [0:NC-1];
   logic signed [COEF_WIDTH-1:0] coef [0:NR-1][0:NC-1];
   logic signed [PW-1:0]         prod_ff [0:NR-1][0:NC-1];

   assign pt[0] = req_bus.in_x;
   assign pt[1] = req_bus.in_y;
   assign pt[2] = req_bus.in_z;
   assign pt[3] = req_bus.in_w;

   always_comb begin
      for (int r = 0; r < NR; r++) begin
         for (int j = 0; j < NC; j++) begin
            coef[r][j] = row_ff[r][vtpd_pkg::SLOT_WIDTH*j +: COEF_WIDTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NR; r++) begin
            for (int j = 0; j < NC; j++) begin
               prod_ff[r][j] <= PW'(pt[j]) * PW'(coef[r][j]);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: row sums t0..t3, exact
   // ---------------------------------------------------------------
   logic signed [SW-1:0] t_ff [0:NR-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NR; r++) begin
            t_ff[r] <= SW'(prod_ff[r][0]) + SW'(prod_ff[r][1])
                     + SW'(prod_ff[r][2]) + SW'(prod_ff[r][3]);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: magnitudes, quotient signs, zero divisor
   // ---------------------------------------------------------------
   logic [SW-1:0] mag_ff [0:NR-1];
   logic [2:0]    qneg3_ff;
   logic          dz3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NR; r++) begin
            mag_ff[r] <= t_ff[r][SW-1] ? SW'(-t_ff[r]) : SW'(t_ff[r]);
         end
         for (int l = 0; l < 3; l++) begin
            qneg3_ff[l] <= t_ff[l][SW-1] ^ t_ff[3][SW-1];
         end
         dz3_ff <= (t_ff[3] == '0);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: overflow precheck and divider setup.
   // Quotient fits in CW bits iff num < den << SH; then CW restoring
   // steps starting from num >> SH give it exactly.
   // ---------------------------------------------------------------
   logic [RW-1:0] rem_ff [0:CW][0:2];
   logic [CW-1:0] low_ff [0:CW][0:2];
   logic [CW-1:0] q_ff   [0:CW][0:2];
   logic [SW-1:0] den_ff [0:CW];
   logic [2:0]    qneg_ff [0:CW];
   logic [2:0]    ovf_ff  [0:CW];
   logic          dz_ff   [0:CW];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            ovf_ff[0][l] <= {SH'(0), mag_ff[l]} >= {mag_ff[3], SH'(0)};
            rem_ff[0][l] <= RW'(mag_ff[l] >> SH);
            low_ff[0][l] <= {mag_ff[l][SH-1:0], FRAC'(0)};
            q_ff[0][l]   <= '0;
         end
         den_ff[0]  <= mag_ff[3];
         qneg_ff[0] <= qneg3_ff;
         dz_ff[0]   <= dz3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Divider stages: one quotient bit per stage per lane
   // ---------------------------------------------------------------
   for (genvar k = 1; k <= CW; k++) begin : g_div
      logic [RW-1:0] trial [0:2];
      logic          take  [0:2];

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            trial[l] = {rem_ff[k-1][l][RW-2:0], low_ff[k-1][l][CW-1]};
            take[l]  = trial[l] >= RW'(den_ff[k-1]);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[k][l] <= take[l] ? trial[l] - RW'(den_ff[k-1]) : trial[l];
               low_ff[k][l] <= {low_ff[k-1][l][CW-2:0], 1'b0};
               q_ff[k][l]   <= {q_ff[k-1][l][CW-2:0], take[l]};
            end
            den_ff[k]  <= den_ff[k-1];
            qneg_ff[k] <= qneg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output stage: saturate, apply sign, force zero on zero divisor
   // ---------------------------------------------------------------
   logic [CW-1:0] lim_in  [0:2];
   logic [CW-1:0] mag_in  [0:2];
   logic [2:0]    sat_in;
   logic [CW-1:0] res_in  [0:2];
   logic [CW-1:0] res_ff  [0:2];
   logic          dz_out_ff;
   logic          sat_out_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lim_in[l] = qneg_ff[CW][l] ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
         sat_in[l] = !dz_ff[CW] && (ovf_ff[CW][l] || (q_ff[CW][l] > lim_in[l]));
         mag_in[l] = sat_in[l] ? lim_in[l] : q_ff[CW][l];
         if (dz_ff[CW]) begin
            res_in[l] = '0;
         end else begin
            res_in[l] = qneg_ff[CW][l] ? -mag_in[l] : mag_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            res_ff[l] <= res_in[l];
         end
         dz_out_ff  <= dz_ff[CW];
         sat_out_ff <= |sat_in;
      end
   end

   assign rsp_bus.valid     = valid_ff[DEPTH-1];
   assign rsp_bus.out_x     = res_ff[0];
   assign rsp_bus.out_y     = res_ff[1];
   assign rsp_bus.out_z     = res_ff[2];
   assign rsp_bus.div_zero  = dz_out_ff;
   assign rsp_bus.saturated = sat_out_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MINV = {1'b1, (CW-1)'(0)};

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.div_zero |->
         rsp_bus.out_x == '0 && rsp_bus.out_y == '0 && rsp_bus.out_z == '0
         && !rsp_bus.saturated)
      else $error("zero divisor word carries nonzero result");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |->
         res_ff[0] == MAXV || res_ff[0] == MINV || res_ff[1] == MAXV
         || res_ff[1] == MINV || res_ff[2] == MAXV || res_ff[2] == MINV)
      else $error("saturated word has no clamped coordinate");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipe valid bits moved during stall");

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for the vertex transform with perspective divide: predicts and checks every word.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   logic signed [31:0] px, py, pz;
   logic               dz, sat;
} proj_type;

class projection_board;
   proj_type      pending[$];
   logic   [63:0] rows[4];
   int            errors;
   int            checked;
   int            dz_seen;
   int            sat_seen;

   function void reset_rows();
      rows[0] = vtpd_pkg::ROW0_RESET;
      rows[1] = vtpd_pkg::ROW1_RESET;
      rows[2] = vtpd_pkg::ROW2_RESET;
      rows[3] = vtpd_pkg::ROW3_RESET;
   endfunction

   function void write_row(logic [2:0] idx, logic [63:0] val);
      if (idx < 3'(vtpd_pkg::NUM_ROWS)) rows[idx[1:0]] = val;
   endfunction

   // Exact row dot product: 32x16 products summed fit easily in 64 signed bits.
   function logic signed [63:0] row_sum(int r, logic signed [31:0] p[4]);
      logic signed [63:0] acc;
      logic signed [15:0] c;
      acc = 0;
      for (int j = 0; j < 4; j++) begin
         c = rows[r][16*j +: 16];
         acc = acc + 64'(c) * 64'(p[j]);
      end
      return acc;
   endfunction

   function logic signed [31:0] quot(logic signed [63:0] n, logic signed [63:0] d,
                                     inout logic sat);
      logic signed [127:0] q;
      q = (128'(n) <<< 16) / 128'(d);
      if (q > 128'sd2147483647) begin
         sat = 1;
         return 32'sh7fffffff;
      end
      if (q < -128'sd2147483648) begin
         sat = 1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function void note_point(logic signed [31:0] p[4]);
      proj_type e;
      logic signed [63:0] t[4];
      logic s;
      for (int i = 0; i < 4; i++) t[i] = row_sum(i, p);
      s = 0;
      if (t[3] == 0) begin
         e.px = 0; e.py = 0; e.pz = 0; e.dz = 1; e.sat = 0;
      end else begin
         e.px = quot(t[0], t[3], s);
         e.py = quot(t[1], t[3], s);
         e.pz = quot(t[2], t[3], s);
         e.dz = 0;
         e.sat = s;
      end
      pending.insert(pending.size(), e);
   endfunction

   function void check_result(proj_type got);
      proj_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result x=%h y=%h z=%h", $time, got.px, got.py, got.pz);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      if (got.dz) dz_seen++;
      if (got.sat) sat_seen++;
      if (got.px !== e.px) begin
         $display("%0t: out_x expected %h actual %h", $time, e.px, got.px);
         errors++;
      end
      if (got.py !== e.py) begin
         $display("%0t: out_y expected %h actual %h", $time, e.py, got.py);
         errors++;
      end
      if (got.pz !== e.pz) begin
         $display("%0t: out_z expected %h actual %h", $time, e.pz, got.pz);
         errors++;
      end
      if (got.dz !== e.dz) begin
         $display("%0t: div_zero expected %b actual %b", $time, e.dz, got.dz);
         errors++;
      end
      if (got.sat !== e.sat) begin
         $display("%0t: saturated expected %b actual %b", $time, e.sat, got.sat);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int LATENCY   = vtpd_pkg::COORD_WIDTH_DEF + 5;
   localparam int MAX_CYCLE = 400000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [vtpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [vtpd_pkg::ROW_WIDTH-1:0]       csr_wdata;

   vtpd_req_if req_bus();
   vtpd_rsp_if rsp_bus();

   vertex_transform_perspective_divide DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   projection_board board;
   int  cycle;
   int  sent;
   bit  calm;          // no random idling on either side while set
   bit  hold_rsp;      // long receiver hold-off, counted by the sink process
   bit  sink_on;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the edge, before the nonblocking updates land.
   always @(posedge clock) begin
      proj_type got;
      cycle <= cycle + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.px = rsp_bus.out_x;
         got.py = rsp_bus.out_y;
         got.pz = rsp_bus.out_z;
         got.dz = rsp_bus.div_zero;
         got.sat = rsp_bus.saturated;
         board.check_result(got);
      end
      if (!reset && req_bus.valid && req_bus.ready) sent <= sent + 1;
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off.
   initial begin
      int left;
      rsp_bus.ready = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && left == 0) left = 300;
         if (left > 0) begin
            left--;
            if (left == 0) hold_rsp = 0;
            rsp_bus.ready <= 0;
         end else if (!sink_on) begin
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
         end
      end
   end

   task automatic drive_csr(logic [vtpd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [vtpd_pkg::ROW_WIDTH-1:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_row(idx, val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Offer one point, called at a clock edge; hold it until the handshake
   // and return at that edge so the next point can follow with no gap.
   task automatic send_point(logic signed [31:0] p[4]);
      while (!calm && $urandom_range(99) < 17) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.in_x <= p[0];
      req_bus.in_y <= p[1];
      req_bus.in_z <= p[2];
      req_bus.in_w <= p[3];
      board.note_point(p);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid, wait until every result came back, then let the pipe drain fully.
   task automatic drain();
      req_bus.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
         2: return 32'sh00010000;
         default: return $urandom_range(3) == 0 ? 32'sh80000000 : 32'sh7fffffff;
      endcase
   endfunction

   function automatic logic [63:0] rand_row(int mode);
      logic [63:0] r;
      for (int j = 0; j < 4; j++) begin
         case (mode)
            0: r[16*j +: 16] = $urandom();
            1: r[16*j +: 16] = $urandom_range(1) ? 16'h1000 : 16'h0000;
            default: r[16*j +: 16] = 16'($signed($urandom_range(8192)) - 4096);
         endcase
      end
      return r;
   endfunction

   task automatic random_phase(int n, int cmode);
      logic signed [31:0] p[4];
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 4; i++) p[i] = rand_coord(cmode == 9 ? $urandom_range(3) : cmode);
         // keep w near one in most sane-geometry points
         if (cmode == 1 && $urandom_range(3) != 0)
            p[3] = 32'sh00010000 + $signed($urandom_range(4096)) - 32'sd2048;
         send_point(p);
      end
   endtask

   initial begin
      logic signed [31:0] p[4];
      logic signed [31:0] edges[6];
      board = new();
      board.reset_rows();
      reset = 1;
      csr_we = 0;
      csr_index = vtpd_pkg::ROW0_IDX;
      csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.in_x = 0;
      req_bus.in_y = 0;
      req_bus.in_z = 0;
      req_bus.in_w = 0;
      calm = 0;
      hold_rsp = 0;
      sink_on = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      sink_on = 1;

      // Directed: identity matrix with field extremes, zero divisor, overflow.
      edges = '{32'sh00000000, 32'sh00010000, 32'sh7fffffff, 32'sh80000000,
                32'shffffffff, 32'sh00000001};
      for (int k = 0; k < 6; k++) begin
         p = '{edges[k], edges[(k+1)%6], edges[(k+2)%6], edges[(k+3)%6]};
         send_point(p);
      end
      p = '{32'sh00050000, -32'sh00030000, 32'sh00020000, 32'sh0};   // zero divisor
      send_point(p);
      p = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh00000001};  // both clamps
      send_point(p);
      p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'shffffffff};
      send_point(p);
      drain();

      // Extreme coefficients: most negative and most positive in every slot.
      drive_csr(vtpd_pkg::ROW0_IDX, 64'h8000_8000_8000_8000);
      drive_csr(vtpd_pkg::ROW1_IDX, 64'h7fff_7fff_7fff_7fff);
      drive_csr(vtpd_pkg::ROW2_IDX, 64'hffff_0001_8000_7fff);
      drive_csr(vtpd_pkg::ROW3_IDX, 64'h8000_7fff_0001_ffff);
      for (int k = 0; k < 6; k++) begin
         p = '{edges[k], edges[5-k], edges[(k+3)%6], edges[(k+1)%6]};
         send_point(p);
      end
      drain();

      // Random phases over several matrices; the second keeps a calm stretch.
      for (int ph = 0; ph < 8; ph++) begin
         int rm;
         rm = ph % 3;
         drive_csr(vtpd_pkg::ROW0_IDX, rand_row(rm));
         drive_csr(vtpd_pkg::ROW1_IDX, rand_row(rm));
         drive_csr(vtpd_pkg::ROW2_IDX, rand_row(rm));
         drive_csr(vtpd_pkg::ROW3_IDX, ph == 5 ? 64'h0 : rand_row(rm));
         calm = (ph == 1);
         if (ph == 3) hold_rsp = 1;   // fill the pipe and stall the sender
         random_phase(210, ph == 0 ? 0 : (ph == 2 ? 9 : 1));
         calm = 0;
         drain();
      end

      // Back to the identity for a last batch.
      drive_csr(vtpd_pkg::ROW0_IDX, vtpd_pkg::ROW0_RESET);
      drive_csr(vtpd_pkg::ROW1_IDX, vtpd_pkg::ROW1_RESET);
      drive_csr(vtpd_pkg::ROW2_IDX, vtpd_pkg::ROW2_RESET);
      drive_csr(vtpd_pkg::ROW3_IDX, vtpd_pkg::ROW3_RESET);
      random_phase(50, 9);
      drain();

      $display("Covered %0d points (%0d sent) over eleven matrix settings;", board.checked,
               sent);
      $display("  %0d zero divisors, %0d clamped.", board.dz_seen, board.sat_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle > MAX_CYCLE) begin
         $display("Timeout at cycle %0d", cycle);
         $display("CHECKS FAILED");
         $finish;
      end
   end
endmodule
`default_nettype wire
